>>> rtl/core/mmfa_pkg.sv
// shared constants, codes and types of the multi-mode queue arbiter
package mmfa_pkg;

  localparam int NUM_QUEUES    = 8;
  localparam int ARRIVAL_DEPTH = 64;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int CW = $clog2(ARRIVAL_DEPTH + 1);

  localparam int MASK_W = 8;
  localparam int PQ_W   = 3;
  localparam int GQ_W   = 3;
  localparam int MODE_W = 3;
  localparam int REQ_N  = (NUM_QUEUES < MASK_W) ? NUM_QUEUES : MASK_W;
  localparam int CNT_W  = $clog2(REQ_N + 1);

  localparam int LFSR_W     = 32;
  localparam int TAP_A      = 1;
  localparam int TAP_B      = 6;
  localparam int TAP_C      = 16;
  localparam int RND_W      = 8;
  localparam int RND_STRIDE = 4;
  localparam int RBW        = $clog2(RND_W);

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;

  localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;

  localparam logic [MODE_W-1:0] MODE_RANDOM = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LRU    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ARRIVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIXED  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RR     = 3'd4;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_ARB  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DEC,
    S_SWEEP,
    S_OUT
  } state_e;

  // common control of the arrival cell row
  typedef struct packed {
    logic          run;
    logic [QW-1:0] win;
    logic [QW-1:0] wr_data;
  } arr_ctl_t;

endpackage

>>> rtl/core/mmfa_arr_cell.sv
// one cell of the arrival order row: holds one queue id, removal token walks the row
module mmfa_arr_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mmfa_pkg::arr_ctl_t       ctl_i,
  input  logic                     wr_sel_i,
  input  logic                     tok_i,
  input  logic                     fnd_i,
  input  logic [mmfa_pkg::QW-1:0]  next_i,
  output logic                     tok_o,
  output logic                     fnd_o,
  output logic [mmfa_pkg::QW-1:0]  entry_o
);

  localparam int QW = mmfa_pkg::QW;

  logic          tok_q;
  logic          fnd_q;
  logic [QW-1:0] entry_q, entry_d;

  assign tok_o   = tok_q & ctl_i.run;
  assign fnd_o   = fnd_q | (entry_q == ctl_i.win);
  assign entry_o = entry_q;

  // once the first match is seen, every cell under the token pulls from its right neighbor
  always_comb begin
    entry_d = entry_q;
    if (wr_sel_i) begin
      entry_d = ctl_i.wr_data;
    end else if (tok_o && fnd_o) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      fnd_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      fnd_q <= fnd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> rtl/core/mmfa_lru_cell.sv
// one cell of the lru order row: holds one queue id, shifts left past the winner
module mmfa_lru_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [mmfa_pkg::QW-1:0]  init_i,
  input  logic                     upd_i,
  input  logic [mmfa_pkg::QW-1:0]  win_i,
  input  logic                     fnd_i,
  input  logic [mmfa_pkg::QW-1:0]  next_i,
  output logic                     fnd_o,
  output logic [mmfa_pkg::QW-1:0]  entry_o
);

  localparam int QW = mmfa_pkg::QW;

  logic [QW-1:0] entry_q, entry_d;

  assign fnd_o   = fnd_i | (entry_q == win_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (upd_i && fnd_o) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= init_i;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

>>> rtl/core/mmfa_rmod.sv
// serial remainder unit, one dividend bit per cycle
module mmfa_rmod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mmfa_pkg::RND_W-1:0]   num_i,
  input  logic [mmfa_pkg::CNT_W-1:0]   den_i,
  output logic                         done_o,
  output logic [mmfa_pkg::CNT_W-1:0]   rem_o
);

  localparam int RND_W = mmfa_pkg::RND_W;
  localparam int CNT_W = mmfa_pkg::CNT_W;
  localparam int RBW   = mmfa_pkg::RBW;

  logic             busy_q;
  logic             done_q;
  logic [RBW-1:0]   bit_q;
  logic [RND_W-1:0] num_q;
  logic [CNT_W-1:0] den_q;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W:0]   trial;
  logic             last_bit;

  assign trial    = {rem_q, num_q[RND_W-1]};
  assign last_bit = bit_q == RBW'(RND_W - 1);
  assign done_o   = done_q;
  assign rem_o    = rem_q;

  // remainder stays below the divisor, so the trial fits one extra bit
  always_comb begin
    if (trial >= {1'b0, den_q}) begin
      rem_d = CNT_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= busy_q && last_bit;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= '0;
      end else if (busy_q) begin
        bit_q <= bit_q + 1'b1;
        if (last_bit) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[RND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

>>> rtl/core/multi_mode_fifo_arbiter_core.sv
// Multi-mode queue arbiter: grants one of the queues by random, lru, arrival order, fixed
// priority or round robin, selected by the mode register (codes five to seven never grant).
// One beat is handled at a time. Every beat passes the decide state, then the output stage,
// and the input is ready again once the output stage has loaded the result beat. In random
// mode, an arbitration beat with a nonzero request count first runs the serial remainder
// unit, which takes one random bit per cycle and then flags the remainder. A grant of a
// queue that has an entry in the arrival list adds a sweep over the stored arrival entries:
// a removal token walks the row of arrival cells and every cell behind the first match
// takes its neighbor's id. A result beat that is not taken holds the next beat in the output
// stage. The arrival list needs no clearing after reset; only its entries below the fill
// count are ever used.
module multi_mode_fifo_arbiter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mmfa_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // push_queue, request_mask
  input  logic                              s_axis_tuser,   // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mmfa_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // grant_valid, grant_queue, push_dropped
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmfa_pkg::PADDR_W-1:0]      paddr,
  input  logic [mmfa_pkg::APB_DW-1:0]       pwdata,
  output logic [mmfa_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int NQ     = mmfa_pkg::NUM_QUEUES;
  localparam int DEPTH  = mmfa_pkg::ARRIVAL_DEPTH;
  localparam int QW     = mmfa_pkg::QW;
  localparam int CW     = mmfa_pkg::CW;
  localparam int MASK_W = mmfa_pkg::MASK_W;
  localparam int PQ_W   = mmfa_pkg::PQ_W;
  localparam int GQ_W   = mmfa_pkg::GQ_W;
  localparam int MODE_W = mmfa_pkg::MODE_W;
  localparam int REQ_N  = mmfa_pkg::REQ_N;
  localparam int CNT_W  = mmfa_pkg::CNT_W;
  localparam int LFSR_W = mmfa_pkg::LFSR_W;
  localparam int RND_W  = mmfa_pkg::RND_W;
  localparam int OUT_PAD = mmfa_pkg::M_TDATA_W - GQ_W - 2;

  function automatic logic [CNT_W-1:0] req_count(input logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < REQ_N; i++) begin
      c = c + CNT_W'(m[i]);
    end
    return c;
  endfunction

  mmfa_pkg::state_e state_q, state_d;

  logic [MODE_W-1:0] mode_q;
  logic [LFSR_W-1:0] lfsr_q;
  logic [QW-1:0]     last_q;
  logic [CW-1:0]     arr_cnt_q;
  logic [CW-1:0]     qcnt_q [NQ];
  logic              m_valid_q;

  logic              cmd_q;
  logic [PQ_W-1:0]   pq_q;
  logic [MASK_W-1:0] mask_q;
  logic [QW-1:0]     win_q;
  logic [CW-1:0]     end_q;
  logic [CW-1:0]     idx_q;
  logic              res_v_q, res_d_q;
  logic [GQ_W-1:0]   res_w_q;
  logic              m_v_q, m_d_q;
  logic [GQ_W-1:0]   m_w_q;

  // beat fields
  logic              in_cmd;
  logic [MASK_W-1:0] in_mask;
  logic [CNT_W-1:0]  in_cnt;
  logic              s_accept;

  // control
  logic cfg_wr;
  logic start_div;
  logic in_dec;
  logic apply;
  logic remove;
  logic push_ok;
  logic drop;
  logic ld_out;
  logic sweep_last;

  // decision datapath
  logic [NQ-1:0]    req;
  logic [RND_W-1:0] rnd_bits;
  logic [CNT_W-1:0] rem;
  logic             div_done;
  logic             grant_v;
  logic [QW-1:0]    grant_w;
  logic             rnd_v, lru_v, fix_v, rr_v, arr_v;
  logic [QW-1:0]    rnd_w, lru_w, fix_w, rr_w, arr_w;
  logic [CNT_W-1:0] seen;
  logic [QW:0]      cand;
  logic [QW-1:0]    qsel;
  logic             present;
  logic             pq_ok;
  logic             arr_full;

  // cell rows
  logic [QW-1:0]        arr_e [DEPTH];
  logic [DEPTH-1:0]     arr_tok;
  logic [DEPTH-1:0]     arr_fnd;
  mmfa_pkg::arr_ctl_t   arr_ctl;
  logic [QW-1:0]        lru_e [NQ];
  logic [NQ-1:0]        lru_f;

  assign in_cmd   = s_axis_tuser;
  assign in_mask  = s_axis_tdata[PQ_W +: MASK_W];
  assign in_cnt   = req_count(in_mask);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  assign cfg_wr = psel && penable && pwrite && pready && (paddr == mmfa_pkg::ADDR_MODE);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr == mmfa_pkg::ADDR_MODE) begin
      prdata[MODE_W-1:0] = mode_q;
    end
  end

  always_comb begin
    for (int i = 0; i < RND_W; i++) begin
      rnd_bits[i] = lfsr_q[i * mmfa_pkg::RND_STRIDE];
    end
  end

  mmfa_rmod u_rmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_div),
    .num_i   (rnd_bits),
    .den_i   (in_cnt),
    .done_o  (div_done),
    .rem_o   (rem)
  );

  // grant decision for the held beat
  always_comb begin
    req = '0;
    for (int q = 0; q < REQ_N; q++) begin
      req[q] = mask_q[q];
    end

    seen  = '0;
    rnd_v = 1'b0;
    rnd_w = '0;
    for (int q = 0; q < NQ; q++) begin
      if (req[q] && !rnd_v) begin
        if (seen == rem) begin
          rnd_v = 1'b1;
          rnd_w = QW'(q);
        end
        seen = seen + 1'b1;
      end
    end

    lru_v = 1'b0;
    lru_w = '0;
    for (int i = 0; i < NQ; i++) begin
      if (!lru_v && req[lru_e[i]]) begin
        lru_v = 1'b1;
        lru_w = lru_e[i];
      end
    end

    fix_v = 1'b0;
    fix_w = '0;
    for (int q = 0; q < NQ; q++) begin
      if (!fix_v && req[q]) begin
        fix_v = 1'b1;
        fix_w = QW'(q);
      end
    end

    rr_v = 1'b0;
    rr_w = '0;
    cand = '0;
    for (int i = 0; i < NQ; i++) begin
      cand = {1'b0, last_q} + (QW + 1)'(i + 1);
      if (cand >= (QW + 1)'(NQ)) begin
        cand = cand - (QW + 1)'(NQ);
      end
      if (!rr_v && req[cand[QW-1:0]]) begin
        rr_v = 1'b1;
        rr_w = cand[QW-1:0];
      end
    end

    arr_v = arr_cnt_q != '0;
    arr_w = arr_e[0];

    grant_v = 1'b0;
    grant_w = '0;
    case (mode_q)
      mmfa_pkg::MODE_RANDOM: begin
        grant_v = rnd_v;
        grant_w = rnd_w;
      end
      mmfa_pkg::MODE_LRU: begin
        grant_v = lru_v;
        grant_w = lru_w;
      end
      mmfa_pkg::MODE_ARRIVE: begin
        grant_v = arr_v;
        grant_w = arr_w;
      end
      mmfa_pkg::MODE_FIXED: begin
        grant_v = fix_v;
        grant_w = fix_w;
      end
      mmfa_pkg::MODE_RR: begin
        grant_v = rr_v;
        grant_w = rr_w;
      end
      default: begin
        grant_v = 1'b0;
        grant_w = '0;
      end
    endcase
  end

  // per-queue entry counts tell at once whether the winner sits in the arrival list
  assign qsel     = (cmd_q == mmfa_pkg::CMD_ARB) ? grant_w : QW'(pq_q);
  assign present  = qcnt_q[qsel] != '0;
  assign pq_ok    = 32'(pq_q) < NQ;
  assign arr_full = arr_cnt_q == CW'(DEPTH);

  assign sweep_last = idx_q == CW'(end_q - 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmfa_pkg::S_IDLE: begin
        if (s_accept) begin
          state_d = start_div ? mmfa_pkg::S_DIV : mmfa_pkg::S_DEC;
        end
      end
      mmfa_pkg::S_DIV: begin
        if (div_done) begin
          state_d = mmfa_pkg::S_DEC;
        end
      end
      mmfa_pkg::S_DEC: begin
        state_d = remove ? mmfa_pkg::S_SWEEP : mmfa_pkg::S_OUT;
      end
      mmfa_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_d = mmfa_pkg::S_OUT;
        end
      end
      mmfa_pkg::S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = mmfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mmfa_pkg::S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = state_q == mmfa_pkg::S_IDLE;
    start_div     = s_accept && (in_cmd == mmfa_pkg::CMD_ARB)
                    && (mode_q == mmfa_pkg::MODE_RANDOM) && (in_cnt != '0);
    in_dec        = state_q == mmfa_pkg::S_DEC;
    apply         = in_dec && (cmd_q == mmfa_pkg::CMD_ARB) && grant_v;
    remove        = apply && present;
    push_ok       = in_dec && (cmd_q == mmfa_pkg::CMD_PUSH) && pq_ok && !arr_full;
    drop          = in_dec && (cmd_q == mmfa_pkg::CMD_PUSH) && pq_ok && arr_full;
    ld_out        = (state_q == mmfa_pkg::S_OUT) && (!m_valid_q || m_axis_tready);
  end

  assign arr_ctl.run     = state_q == mmfa_pkg::S_SWEEP;
  assign arr_ctl.win     = win_q;
  assign arr_ctl.wr_data = QW'(pq_q);

  for (genvar k = 0; k < DEPTH; k++) begin : g_arr
    logic          tok_in;
    logic          fnd_in;
    logic [QW-1:0] next_in;

    if (k == 0) begin : g_head
      assign tok_in = remove;
      assign fnd_in = 1'b0;
    end else begin : g_body
      assign tok_in = arr_tok[k-1];
      assign fnd_in = arr_fnd[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign next_in = arr_e[k];
    end else begin : g_mid
      assign next_in = arr_e[k+1];
    end

    mmfa_arr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (arr_ctl),
      .wr_sel_i (push_ok && (arr_cnt_q == CW'(k))),
      .tok_i    (tok_in),
      .fnd_i    (fnd_in),
      .next_i   (next_in),
      .tok_o    (arr_tok[k]),
      .fnd_o    (arr_fnd[k]),
      .entry_o  (arr_e[k])
    );
  end

  for (genvar i = 0; i < NQ; i++) begin : g_lru
    logic          fnd_in;
    logic [QW-1:0] next_in;

    if (i == 0) begin : g_head
      assign fnd_in = 1'b0;
    end else begin : g_body
      assign fnd_in = lru_f[i-1];
    end

    // the tail cell receives the winner
    if (i == NQ - 1) begin : g_tail
      assign next_in = grant_w;
    end else begin : g_mid
      assign next_in = lru_e[i+1];
    end

    mmfa_lru_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .init_i  (QW'(i)),
      .upd_i   (apply),
      .win_i   (grant_w),
      .fnd_i   (fnd_in),
      .next_i  (next_in),
      .fnd_o   (lru_f[i]),
      .entry_o (lru_e[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmfa_pkg::S_IDLE;
      mode_q    <= mmfa_pkg::MODE_RANDOM;
      lfsr_q    <= LFSR_W'(1);
      last_q    <= QW'(NQ - 1);
      arr_cnt_q <= '0;
      qcnt_q    <= '{default: '0};
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        mode_q <= pwdata[MODE_W-1:0];
      end
      if (apply) begin
        lfsr_q <= {lfsr_q[LFSR_W-2:0], lfsr_q[mmfa_pkg::TAP_A] ^ lfsr_q[mmfa_pkg::TAP_B]
                   ^ lfsr_q[mmfa_pkg::TAP_C]};
        last_q <= grant_w;
      end
      if (remove) begin
        qcnt_q[qsel] <= qcnt_q[qsel] - 1'b1;
        arr_cnt_q    <= arr_cnt_q - 1'b1;
      end else if (push_ok) begin
        qcnt_q[qsel] <= qcnt_q[qsel] + 1'b1;
        arr_cnt_q    <= arr_cnt_q + 1'b1;
      end
      if (in_dec) begin
        idx_q <= '0;
      end else if (arr_ctl.run) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ld_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= in_cmd;
      pq_q   <= s_axis_tdata[PQ_W-1:0];
      mask_q <= in_mask;
    end
    if (in_dec) begin
      win_q   <= grant_w;
      end_q   <= arr_cnt_q;
      res_v_q <= apply;
      res_w_q <= apply ? GQ_W'(grant_w) : '0;
      res_d_q <= drop;
    end
    if (ld_out) begin
      m_v_q <= res_v_q;
      m_w_q <= res_w_q;
      m_d_q <= res_d_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, m_d_q, m_w_q, m_v_q};

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arr_cnt_q <= CW'(DEPTH))
    else $error("arrival count beyond depth");

  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(arr_tok))
    else $error("more than one removal token in the arrival row");

  a_sweep_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mmfa_pkg::S_DEC && state_d == mmfa_pkg::S_SWEEP)
    |=> (CW'(arr_cnt_q + 1'b1) == $past(arr_cnt_q)))
    else $error("removal sweep without arrival count decrement");

  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[GQ_W + 1]))
    else $error("grant and dropped push in one result beat");
`endif

endmodule

>>> dv/multi_mode_fifo_arbiter_core_test.sv
// stream-level testbench of the multi-mode queue arbiter with a self-checking grant predictor
module multi_mode_fifo_arbiter_core_test;
  import mmfa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 12;

  // mode codes with no arbitration scheme behind them
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic              cmd;
    logic [PQ_W-1:0]   pq;
    logic [MASK_W-1:0] mask;
  } arb_item_t;

  typedef struct packed {
    logic            gv;
    logic [GQ_W-1:0] gq;
    logic            drop;
  } grant_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // push_queue, request_mask
  logic                 s_axis_tuser = 1'b0; // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // grant_valid, grant_queue, push_dropped
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  arb_item_t   arb_items_q[$];
  grant_beat_t grant_beats_q[$];

  // predictor state
  logic [MODE_W-1:0] mode_q;
  logic [LFSR_W-1:0] lfsr_q;
  logic [QW-1:0]     lru_q [NUM_QUEUES];
  logic [QW-1:0]     last_grant_q;
  logic [QW-1:0]     arrivals_q[$];

  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  int  hold_left    = 0;
  bit  hold_taken   = 1'b0;
  bit  hold_arm     = 1'b0;
  bit  src_calm     = 1'b0;
  bit  sink_calm    = 1'b0;

  multi_mode_fifo_arbiter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // works out the grant beat of one accepted item and advances the arbiter state
  function automatic grant_beat_t predict_grant(arb_item_t it);
    grant_beat_t res;
    logic [QW-1:0] win;
    int r;
    int cnt;
    int pick;
    int seen;
    int j;
    bit hit;
    res = '0;
    win = '0;
    if (it.cmd == CMD_PUSH) begin
      if (arrivals_q.size() < ARRIVAL_DEPTH) arrivals_q.push_back(it.pq);
      else res.drop = 1'b1;
      return res;
    end
    case (mode_q)
      MODE_RANDOM: begin
        r = 0;
        for (int i = 0; i < RND_W; i++) r[i] = lfsr_q[i*RND_STRIDE];
        cnt = $countones(it.mask);
        if (cnt != 0) begin
          pick = r % cnt;
          seen = 0;
          for (int i = 0; i < NUM_QUEUES; i++) begin
            if (it.mask[i] && !res.gv) begin
              if (seen == pick) begin
                res.gv = 1'b1;
                win = QW'(i);
              end
              seen++;
            end
          end
        end
      end
      MODE_LRU: begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (!res.gv && it.mask[lru_q[i]]) begin
            res.gv = 1'b1;
            win = lru_q[i];
          end
        end
      end
      MODE_ARRIVE: begin
        // the request mask plays no part here
        if (arrivals_q.size() != 0) begin
          res.gv = 1'b1;
          win = arrivals_q[0];
        end
      end
      MODE_FIXED: begin
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
          if (it.mask[i]) begin
            res.gv = 1'b1;
            win = QW'(i);
          end
        end
      end
      MODE_RR: begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
          j = (int'(last_grant_q) + 1 + i) % NUM_QUEUES;
          if (!res.gv && it.mask[j]) begin
            res.gv = 1'b1;
            win = QW'(j);
          end
        end
      end
      default: ;
    endcase
    if (res.gv) begin
      lfsr_q = {lfsr_q[LFSR_W-2:0], lfsr_q[TAP_A] ^ lfsr_q[TAP_B] ^ lfsr_q[TAP_C]};
      hit = 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        if (hit) lru_q[i-1] = lru_q[i];
        else if (lru_q[i] == win) hit = 1'b1;
      end
      lru_q[NUM_QUEUES-1] = win;
      hit = 1'b0;
      for (int i = 0; i < arrivals_q.size(); i++) begin
        if (!hit && arrivals_q[i] == win) begin
          arrivals_q.delete(i);
          hit = 1'b1;
        end
      end
      last_grant_q = win;
      res.gq = win;
    end
    return res;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    arb_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (arb_items_q.size() != 0 && (src_calm || $urandom_range(99) >= 10)) begin
        it = arb_items_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= S_TDATA_W'({it.mask, it.pq});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= sink_calm || ($urandom_range(99) >= 10);
    end
  end

  // prediction on accepted items, checking on accepted results
  always @(posedge clk_i) begin
    grant_beat_t exp_beat;
    grant_beat_t got;
    if (!rst_ni) begin
      mode_q       = MODE_RANDOM;
      lfsr_q       = 32'd1;
      last_grant_q = QW'(NUM_QUEUES - 1);
      for (int i = 0; i < NUM_QUEUES; i++) lru_q[i] = QW'(i);
      arrivals_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_MODE)
        mode_q = pwdata[MODE_W-1:0];
      if (s_axis_tvalid && s_axis_tready)
        grant_beats_q.push_back(predict_grant({s_axis_tuser, s_axis_tdata[PQ_W-1:0],
                                               s_axis_tdata[PQ_W +: MASK_W]}));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[4]};
        if (grant_beats_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          exp_beat = grant_beats_q.pop_front();
          if (got.gv !== exp_beat.gv) begin
            $error("grant_valid: expected %0d, got %0d", exp_beat.gv, got.gv);
            mismatch_cnt++;
          end
          if (got.gq !== exp_beat.gq) begin
            $error("grant_queue: expected %0d, got %0d", exp_beat.gq, got.gq);
            mismatch_cnt++;
          end
          if (got.drop !== exp_beat.drop) begin
            $error("push_dropped: expected %0d, got %0d", exp_beat.drop, got.drop);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_beat(logic cmd, logic [PQ_W-1:0] pq, logic [MASK_W-1:0] mask);
    arb_items_q.push_back('{cmd: cmd, pq: pq, mask: mask});
  endtask

  // blocks until every item is in and every grant beat is out
  task automatic wait_quiet();
    @(negedge clk_i);
    while (arb_items_q.size() != 0 || s_axis_tvalid || grant_beats_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    wait_quiet();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODE;
    pwdata  <= APB_DW'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return MASK_W'(1) << $urandom_range(MASK_W - 1);
      default: return MASK_W'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_mixed(int n);
    for (int i = 0; i < n; i++)
      queue_beat($urandom_range(1) ? CMD_ARB : CMD_PUSH, PQ_W'($urandom_range(7)), rand_mask());
  endtask

  initial begin
    logic [MODE_W-1:0] modes [12];
    modes = '{MODE_RANDOM, MODE_LRU, MODE_ARRIVE, MODE_FIXED, MODE_RR, MODE_RSVD7,
              MODE_RANDOM, MODE_RR, MODE_LRU, MODE_FIXED, MODE_ARRIVE, MODE_RSVD5};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // arrival order: empty list, then mask ignored, then drained past empty
    write_mode(MODE_ARRIVE);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_PUSH, 3'd7, '0);
    queue_beat(CMD_PUSH, 3'd0, '0);
    queue_beat(CMD_PUSH, 3'd7, '0);
    queue_beat(CMD_ARB, '0, '0);
    queue_beat(CMD_ARB, '0, '0);
    queue_beat(CMD_ARB, '0, '0);
    queue_beat(CMD_ARB, '0, '0);
    // fixed priority with an empty arrival list
    write_mode(MODE_FIXED);
    queue_beat(CMD_ARB, '0, '0);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_ARB, '0, 8'h80);
    write_mode(MODE_RR);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_ARB, '0, 8'h81);
    queue_beat(CMD_ARB, '0, 8'h81);
    write_mode(MODE_RANDOM);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_ARB, '0, 8'h80);
    queue_beat(CMD_ARB, '0, 8'h55);
    queue_beat(CMD_ARB, '0, '0);
    write_mode(MODE_LRU);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_ARB, '0, 8'h0F);
    // modes without a scheme never grant, pushes still land
    write_mode(MODE_RSVD6);
    queue_beat(CMD_ARB, '0, '1);
    queue_beat(CMD_PUSH, 3'd3, '0);

    // overfill the arrival list behind one long sink hold-off, then take entries off it by grants
    write_mode(MODE_ARRIVE);
    hold_arm = 1'b1;
    for (int i = 0; i < ARRIVAL_DEPTH + 6; i++)
      queue_beat(CMD_PUSH, PQ_W'($urandom_range(7)), MASK_W'($urandom_range(255)));
    for (int i = 0; i < 30; i++)
      queue_beat(CMD_ARB, PQ_W'($urandom_range(7)), rand_mask());

    foreach (modes[k]) begin
      write_mode(modes[k]);
      src_calm  = (k == 6);
      sink_calm = (k == 6);
      queue_mixed(30);
    end

    wait_quiet();
    if (mismatch_cnt == 0 && grant_beats_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> multi_mode_fifo_arbiter_core.f
rtl/core/mmfa_pkg.sv
rtl/core/mmfa_arr_cell.sv
rtl/core/mmfa_lru_cell.sv
rtl/core/mmfa_rmod.sv
rtl/core/multi_mode_fifo_arbiter_core.sv
dv/multi_mode_fifo_arbiter_core_test.sv
